// ===== rtl/core/assert_macros.svh =====
// assertion helpers used by the lcdx_checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define LCDX_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked on every clock edge, reset included
`define LCDX_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

// ===== rtl/core/lcdx_pkg.sv =====
`default_nettype none

package lcdx_pkg;

    localparam int LCDX_QUEUE_DEPTH = 2;

    // expander port bit map
    localparam logic [7:0] PIN_RS     = 8'h01;
    localparam logic [7:0] PIN_RW     = 8'h02;
    localparam logic [7:0] PIN_E      = 8'h04;
    localparam logic [7:0] NIBBLE_HI  = 8'hF0;
    localparam logic [7:0] NIBBLE_LO  = 8'h0F;
    localparam logic [7:0] SET_DDRAM  = 8'h80;
    localparam logic [7:0] MASK_RESET = 8'h08;
    localparam logic [7:0] NUM_COLS   = 8'd16;
    localparam logic [7:0] NUM_ROWS   = 8'd2;

    // port bytes per transferred lcd byte, and last step indexes
    localparam logic [3:0] STEPS_PER_BYTE = 4'd7;
    localparam logic [3:0] LAST_STEP_ONE  = 4'd6;
    localparam logic [3:0] LAST_STEP_TWO  = 4'd13;

    typedef enum logic [1:0] {
        CMD_INSTR     = 2'd0,
        CMD_DATA      = 2'd1,
        CMD_BACKLIGHT = 2'd2,
        CMD_CHAR_AT   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        OP_INSTR     = 2'd0,
        OP_DATA      = 2'd1,
        OP_BACKLIGHT = 2'd2,
        OP_CHAR_AT   = 2'd3
    } t_op_kind;

    typedef struct packed {
        t_op_kind   kind;
        logic [7:0] value;
        logic [7:0] addr;
    } t_op;

    // queue handshake toward the back end
    typedef struct packed {
        logic valid;
        logic full;
    } t_queue_status;

    // one step of the 4-bit write sequence applied to the port shadow
    function automatic logic [7:0] step_shadow(input logic [7:0] sh,
                                               input logic [2:0] phase,
                                               input logic [7:0] b,
                                               input logic       rs);
        logic [7:0] res;
        res = sh;
        case (phase)
            3'd0:    res = (sh & ~(PIN_RS | PIN_RW)) | (rs ? PIN_RS : 8'h00);
            3'd1:    res = (sh & NIBBLE_LO) | (b & NIBBLE_HI);
            3'd2:    res = sh | PIN_E;
            3'd3:    res = sh & ~PIN_E;
            3'd4:    res = (sh & NIBBLE_LO) | ({b[3:0], 4'h0} & NIBBLE_HI);
            3'd5:    res = sh | PIN_E;
            3'd6:    res = sh & ~PIN_E;
            default: res = sh;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lcdx_if.sv =====
`default_nettype none

interface lcdx_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] value;
    logic [7:0] col;
    logic [7:0] row;

    modport source (output valid, output cmd, output value, output col, output row,
                    input ready);
    modport sink   (input valid, input cmd, input value, input col, input row,
                    output ready);
endinterface

interface lcdx_port_if;
    logic       valid;
    logic       ready;
    logic [7:0] port_byte;
    logic       last;

    modport source (output valid, output port_byte, output last, input ready);
    modport sink   (input valid, input port_byte, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lcdx_front.sv =====
`default_nettype none

module lcdx_front
    import lcdx_pkg::*;
(
    lcdx_req_if.sink     i_req,
    input  t_queue_status i_status,
    output logic          o_push,
    output t_op           o_op
);

    logic       in_range;
    logic [7:0] row_base;
    t_cmd       cmd;

    assign cmd      = t_cmd'(i_req.cmd);
    assign in_range = (i_req.col < NUM_COLS) && (i_req.row < NUM_ROWS);
    // row 0 or 1 lands at ddram offset 0x00 or 0x40
    assign row_base = {1'b0, i_req.row[0], 6'd0};

    assign i_req.ready = !i_status.full;

    // out of range char-at items are taken and dropped
    assign o_push = i_req.valid && !i_status.full && ((cmd != CMD_CHAR_AT) || in_range);

    always_comb begin
        o_op.value = i_req.value;
        o_op.addr  = SET_DDRAM | (row_base + i_req.col);
        case (cmd)
            CMD_INSTR:     o_op.kind = OP_INSTR;
            CMD_DATA:      o_op.kind = OP_DATA;
            CMD_BACKLIGHT: o_op.kind = OP_BACKLIGHT;
            CMD_CHAR_AT:   o_op.kind = OP_CHAR_AT;
            default:       o_op.kind = OP_INSTR;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/lcdx_queue.sv =====
`default_nettype none

module lcdx_queue
    import lcdx_pkg::*;
#(
    parameter int DEPTH = LCDX_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_op           i_op,
    input  logic          i_pop,
    output t_queue_status o_status,
    output t_op           o_op
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_op           r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.valid = (r_count != '0);
    assign o_op           = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lcdx_back.sv =====
`default_nettype none

module lcdx_back
    import lcdx_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_wdata,
    input  t_queue_status i_status,
    input  t_op           i_op,
    output logic          o_pop,
    lcdx_port_if.source   o_port
);

    logic [7:0] r_mask;
    logic [7:0] r_shadow, n_shadow;
    logic [3:0] r_step, n_step;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic       second;
    logic [2:0] phase;
    logic [7:0] cur_byte;
    logic       cur_rs;
    logic       last_step;
    logic       fire;

    assign second = (r_step >= STEPS_PER_BYTE);
    assign phase  = second ? 3'(r_step - STEPS_PER_BYTE) : r_step[2:0];

    always_comb begin
        cur_byte  = i_op.value;
        cur_rs    = 1'b0;
        last_step = (r_step == LAST_STEP_ONE);
        case (i_op.kind)
            OP_INSTR: begin
                cur_rs = 1'b0;
            end
            OP_DATA: begin
                cur_rs = 1'b1;
            end
            OP_BACKLIGHT: begin
                last_step = 1'b1;
            end
            OP_CHAR_AT: begin
                // address write first, then the character
                cur_byte  = second ? i_op.value : i_op.addr;
                cur_rs    = second;
                last_step = (r_step == LAST_STEP_TWO);
            end
            default: begin
                cur_rs = 1'b0;
            end
        endcase

        if (i_op.kind == OP_BACKLIGHT) begin
            n_shadow = (r_shadow & ~r_mask) | ((i_op.value != 8'h00) ? r_mask : 8'h00);
        end else begin
            n_shadow = step_shadow(r_shadow, phase, cur_byte, cur_rs);
        end
        n_step = last_step ? 4'd0 : r_step + 4'd1;
    end

    // one port byte per cycle whenever the queue holds an item and the output register is free
    assign fire  = i_status.valid && (!r_out_valid || o_port.ready);
    assign o_pop = fire && last_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= MASK_RESET;
            r_shadow    <= MASK_RESET;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mask <= i_cfg_wdata;
            end
            if (fire) begin
                r_shadow    <= n_shadow;
                r_step      <= n_step;
                r_out_valid <= 1'b1;
            end else if (o_port.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_byte <= n_shadow;
            r_out_last <= last_step;
        end
    end

    assign o_port.valid     = r_out_valid;
    assign o_port.port_byte = r_out_byte;
    assign o_port.last      = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/core/char_lcd_expander_sequencer.sv =====
// HD44780 4-bit sequencer for an 8-bit port expander (RS bit 0, RW bit 1, E bit 2, backlight
// mask, data bits 7..4). Each accepted item becomes a run of port bytes on o_port, the final one
// flagged with last: 7 bytes for a command or data byte, 1 for set backlight, 14 for a character
// at a position, none for a position off the 16x2 screen. The back-end sequencer puts out one
// port byte per cycle unless o_port.ready holds it back; the queue between the
// front end and the sequencer holds QUEUE_DEPTH items, the running one included, so up to
// QUEUE_DEPTH - 1 further items are taken while a sequence runs.
// The backlight mask register (reset 0x08) takes effect at the next set-backlight item; write
// it only while the block is idle.
`default_nettype none

module char_lcd_expander_sequencer
    import lcdx_pkg::*;
#(
    parameter int QUEUE_DEPTH = LCDX_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    lcdx_req_if.sink    i_req,
    lcdx_port_if.source o_port
);

    t_queue_status status;
    logic          push;
    logic          pop;
    t_op           push_op;
    t_op           head_op;

    lcdx_front u_front (
        .i_req    (i_req),
        .i_status (status),
        .o_push   (push),
        .o_op     (push_op)
    );

    lcdx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_op     (push_op),
        .i_pop    (pop),
        .o_status (status),
        .o_op     (head_op)
    );

    lcdx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_status    (status),
        .i_op        (head_op),
        .o_pop       (pop),
        .o_port      (o_port)
    );

endmodule

`default_nettype wire

// ===== rtl/core/lcdx_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module lcdx_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    // a stalled port byte holds
    `LCDX_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte) && $stable(i_out_last), "port byte changed while stalled")

    // a sequence runs without gaps until its last byte
    `LCDX_ASSERT(a_no_gap, i_out_valid && i_out_ready && !i_out_last |=> i_out_valid, "gap inside a port byte sequence")

    // nothing comes out right after reset
    `LCDX_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !i_out_valid, "output valid after reset")

endmodule

bind char_lcd_expander_sequencer lcdx_checker u_lcdx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_port.valid),
    .i_out_ready (o_port.ready),
    .i_out_byte  (o_port.port_byte),
    .i_out_last  (o_port.last)
);

`default_nettype wire

// ===== sim/lcdx_port_checker.sv =====
`timescale 1ns / 1ps

module lcdx_port_checker
    import lcdx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    lcdx_req_if        i_req,
    lcdx_port_if       i_port,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct {
        logic [7:0] port_byte;
        logic       last;
    } t_port_write;

    t_port_write port_writes_due[$];
    logic [7:0]  mask_model;
    logic [7:0]  shadow_model;
    int          fail_count;

    initial begin
        fail_count   = 0;
        o_fail_count = 0;
        o_pending    = 0;
        mask_model   = MASK_RESET;
        shadow_model = MASK_RESET;
    end

    task automatic emit_shadow();
        t_port_write w;
        w.port_byte = shadow_model;
        w.last      = 1'b0;
        port_writes_due.push_back(w);
    endtask

    task automatic pulse_enable();
        shadow_model = shadow_model | PIN_E;
        emit_shadow();
        shadow_model = shadow_model & ~PIN_E;
        emit_shadow();
    endtask

    // one lcd byte as two nibbles, each strobed by E
    task automatic send_lcd_byte(input logic [7:0] lcd_byte, input logic rs);
        shadow_model = rs ? (shadow_model | PIN_RS) : (shadow_model & ~PIN_RS);
        shadow_model = shadow_model & ~PIN_RW;
        emit_shadow();
        shadow_model = (shadow_model & NIBBLE_LO) | (lcd_byte & NIBBLE_HI);
        emit_shadow();
        pulse_enable();
        shadow_model = (shadow_model & NIBBLE_LO) | {lcd_byte[3:0], 4'h0};
        emit_shadow();
        pulse_enable();
    endtask

    task automatic predict_port_writes(input logic [1:0] cmd, input logic [7:0] value,
                                       input logic [7:0] col, input logic [7:0] row);
        int         first_idx;
        logic [7:0] ddram_addr;
        first_idx = port_writes_due.size();
        case (t_cmd'(cmd))
            CMD_INSTR: begin
                send_lcd_byte(value, 1'b0);
            end
            CMD_DATA: begin
                send_lcd_byte(value, 1'b1);
            end
            CMD_BACKLIGHT: begin
                shadow_model = shadow_model & ~mask_model;
                if (value != 8'h00)
                    shadow_model = shadow_model | mask_model;
                emit_shadow();
            end
            default: begin
                // position off the screen is dropped silently
                if (col < NUM_COLS && row < NUM_ROWS) begin
                    ddram_addr = SET_DDRAM | ((row << 6) + col);
                    send_lcd_byte(ddram_addr, 1'b0);
                    send_lcd_byte(value, 1'b1);
                end
            end
        endcase
        if (port_writes_due.size() > first_idx)
            port_writes_due[port_writes_due.size() - 1].last = 1'b1;
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    always @(posedge i_clk) begin
        t_port_write want;
        if (!i_rst_n) begin
            mask_model   = MASK_RESET;
            shadow_model = MASK_RESET;
            port_writes_due.delete();
        end else begin
            if (i_cfg_we)
                mask_model = i_cfg_wdata;
            if (i_req.valid && i_req.ready)
                predict_port_writes(i_req.cmd, i_req.value, i_req.col, i_req.row);
            if (i_port.valid && i_port.ready) begin
                if (port_writes_due.size() == 0) begin
                    note_failure($sformatf("unexpected port write: byte %02h last %0b at %0t",
                                           i_port.port_byte, i_port.last, $realtime));
                end else begin
                    want = port_writes_due.pop_front();
                    if (i_port.port_byte !== want.port_byte || i_port.last !== want.last)
                        note_failure($sformatf(
                            "port write mismatch at %0t: expected byte %02h last %0b, got byte %02h last %0b",
                            $realtime, want.port_byte, want.last, i_port.port_byte, i_port.last));
                end
            end
        end
        o_pending    <= port_writes_due.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import lcdx_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_TICKS = 40;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;
    int         fail_count;
    int         pending;
    int         cycles;
    int         stall_left;
    bit         idle_on;

    lcdx_req_if  req_ch ();
    lcdx_port_if port_ch ();

    char_lcd_expander_sequencer u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch),
        .o_port      (port_ch)
    );

    lcdx_port_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_req        (req_ch),
        .i_port       (port_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // receiver back-pressure in random bursts
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            port_ch.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            port_ch.ready <= 1'b0;
        end else begin
            port_ch.ready <= 1'b1;
        end
    end

    // valid stays high from the previous item unless a gap is inserted here
    task automatic put_request(input logic [1:0] cmd, input logic [7:0] value,
                               input logic [7:0] col, input logic [7:0] row);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd   <= cmd;
        req_ch.value <= value;
        req_ch.col   <= col;
        req_ch.row   <= row;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task automatic settle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_mask(input logic [7:0] mask);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mask;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_requests(input int count);
        logic [1:0] cmd;
        logic [7:0] value;
        logic [7:0] col;
        logic [7:0] row;
        for (int i = 0; i < count; i++) begin
            cmd   = 2'($urandom_range(0, 3));
            value = 8'($urandom_range(0, 255));
            col   = 8'($urandom_range(0, 255));
            row   = 8'($urandom_range(0, 255));
            if (cmd == CMD_BACKLIGHT && $urandom_range(0, 2) == 0)
                value = 8'h00;
            // keep most positions on screen so the full sequence runs
            if (cmd == CMD_CHAR_AT && $urandom_range(0, 4) != 0) begin
                col = 8'($urandom_range(0, 15));
                row = 8'($urandom_range(0, 1));
            end
            put_request(cmd, value, col, row);
        end
    endtask

    initial begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 8'h00;
        req_ch.valid  = 1'b0;
        req_ch.cmd    = CMD_INSTR;
        req_ch.value  = 8'h00;
        req_ch.col    = 8'h00;
        req_ch.row    = 8'h00;
        port_ch.ready = 1'b0;
        cycles        = 0;
        stall_left    = 0;
        idle_on       = 1'b1;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        write_mask(MASK_RESET);
        put_request(CMD_INSTR, 8'h00, 8'h00, 8'h00);
        put_request(CMD_INSTR, 8'hFF, 8'hFF, 8'hFF);
        put_request(CMD_INSTR, 8'hA5, 8'h5A, 8'hC3);
        put_request(CMD_DATA, 8'h5A, 8'h00, 8'h00);
        put_request(CMD_DATA, 8'hFF, 8'hAA, 8'h55);
        put_request(CMD_DATA, 8'h00, 8'hFF, 8'hFF);
        put_request(CMD_BACKLIGHT, 8'h00, 8'h00, 8'h00);
        put_request(CMD_INSTR, 8'h3C, 8'h00, 8'h00);
        put_request(CMD_BACKLIGHT, 8'h01, 8'hFF, 8'hFF);
        put_request(CMD_BACKLIGHT, 8'h80, 8'h12, 8'h34);
        put_request(CMD_BACKLIGHT, 8'hFF, 8'h00, 8'h00);
        put_request(CMD_CHAR_AT, 8'h41, 8'h00, 8'h00);
        put_request(CMD_CHAR_AT, 8'hFF, 8'h0F, 8'h01);
        put_request(CMD_CHAR_AT, 8'h00, 8'h07, 8'h01);
        put_request(CMD_CHAR_AT, 8'h42, 8'h10, 8'h00);
        put_request(CMD_CHAR_AT, 8'h43, 8'h00, 8'h02);
        put_request(CMD_CHAR_AT, 8'h44, 8'hFF, 8'hFF);
        put_request(CMD_CHAR_AT, 8'h45, 8'h0F, 8'h80);
        put_request(CMD_DATA, 8'h0F, 8'h00, 8'h00);
        put_request(CMD_CHAR_AT, 8'hC3, 8'h0A, 8'h00);
        settle();

        write_mask(8'h00);
        random_requests(60);
        settle();

        write_mask(8'hFF);
        random_requests(60);
        settle();

        write_mask(8'($urandom_range(0, 255)));
        random_requests(60);
        settle();

        // mask over the control and data bits
        case ($urandom_range(0, 3))
            0:       write_mask(PIN_RS);
            1:       write_mask(PIN_RW);
            2:       write_mask(PIN_E);
            default: write_mask(8'h80);
        endcase
        random_requests(50);
        settle();

        idle_on = 1'b0;
        write_mask(MASK_RESET);
        random_requests(60);
        settle();

        if (fail_count == 0 && pending == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
